>>> hw/rtl/cdd_pkg.sv
// Shared types and constants for the calendar display digit converter.
// Holds the pipeline word layout, the output word layout and the month table.
// No dependencies.
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned NUM_STAGES = 7;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 40;

  localparam logic [10:0] MINUTE_MAX = 11'd1439;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  // Reciprocal multipliers: x / d == (x * R) >> S over the value range used.
  localparam logic [13:0] THOU_RECIP = 14'd8389;  // shift 23, year <= 9999
  localparam logic [10:0] HOUR_RECIP = 11'd1093;  // shift 16, minute <= 1439
  localparam logic [5:0]  HUND_RECIP = 6'd41;     // shift 12, value <= 999
  localparam logic [7:0]  TEN_RECIP  = 8'd205;    // shift 11, value <= 99

  localparam logic [8:0] YEAR_LEN     = 9'd365;
  localparam int unsigned NUM_BOUNDS  = 11;

  // Last ordinal day of January through November in a common year.
  function automatic logic [8:0] month_end(input logic [3:0] idx);
    logic [8:0] val;
    case (idx)
      4'd0:    val = 9'd31;
      4'd1:    val = 9'd59;
      4'd2:    val = 9'd90;
      4'd3:    val = 9'd120;
      4'd4:    val = 9'd151;
      4'd5:    val = 9'd181;
      4'd6:    val = 9'd212;
      4'd7:    val = 9'd243;
      4'd8:    val = 9'd273;
      4'd9:    val = 9'd304;
      4'd10:   val = 9'd334;
      default: val = 9'd365;
    endcase
    return val;
  endfunction

  typedef struct packed {
    logic [10:0] minute;
    logic [8:0]  day;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  mins;
    logic [9:0]  rem_hund;
    logic [6:0]  rem_ten;
    logic        leap;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [1:0]  hour_tens;
    logic [3:0]  hour_ones;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic        month_tens;
    logic [3:0]  month_ones;
    logic [1:0]  day_tens;
    logic [3:0]  day_ones;
    logic [3:0]  year_thousands;
    logic [3:0]  year_hundreds;
    logic [3:0]  year_tens;
    logic [3:0]  year_ones;
  } pipe_t;

  // Output word, first member in the highest bits.
  typedef struct packed {
    logic [3:0] year_ones;
    logic [3:0] year_tens;
    logic [3:0] year_hundreds;
    logic [3:0] year_thousands;
    logic [3:0] day_ones;
    logic [1:0] day_tens;
    logic [3:0] month_ones;
    logic       month_tens;
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
  } out_t;

endpackage

>>> hw/rtl/calendar_display_digits_top.sv
// Calendar display digit converter, top level: seven-stage stream pipeline.
// Depends on cdd_pkg for the pipeline word, the output word and the month table.
//
//   channel   dir  tdata fields (lowest bit up)
//   s_axis    in   minute_of_day[10:0], day_of_year[19:11], calendar_year[33:20], zero[39:34]
//   m_axis    out  see port comment below
//
// Every word passes through seven register stages; one word is taken per cycle while the
// output side is not stalled.
// The depth is set by the chain of constant-reciprocal multiplies that split the year.
// Each stage holds its word until the next stage frees up, so a stall fills the bubbles first.
// Reset clears all valid bits, so the input is ready as soon as reset is released.
`timescale 1ns / 1ps

module calendar_display_digits_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // minute_of_day[10:0], day_of_year[19:11], calendar_year[33:20], zero[39:34]
  input  logic [cdd_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // hour_tens[1:0], hour_ones[5:2], minute_tens[8:6], minute_ones[12:9], month_tens[13],
  // month_ones[17:14], day_tens[19:18], day_ones[23:20], year_thousands[27:24],
  // year_hundreds[31:28], year_tens[35:32], year_ones[39:36]
  output logic [cdd_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready
);

  localparam int unsigned N = cdd_pkg::NUM_STAGES;

  cdd_pkg::pipe_t       st_q [N];
  cdd_pkg::pipe_t       st_d [N];
  logic [N-1:0]         vld_q;
  logic [N:0]           adv;
  cdd_pkg::out_t        out_w;

  always_comb begin
    adv[N] = m_axis_tready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_comb begin
    logic [10:0] min_raw;
    logic [13:0] yr_raw;
    logic [27:0] p_thou;
    logic [21:0] p_hour;
    logic [15:0] p_hund;
    logic [13:0] p_mt;
    logic [14:0] p_yt;
    logic [1:0]  cent_low;
    logic        leap;
    logic [8:0]  len;
    logic [8:0]  dclamp;
    logic [8:0]  bound;
    logic [8:0]  start;
    logic [3:0]  mon;

    min_raw = s_axis_tdata[10:0];
    yr_raw  = s_axis_tdata[33:20];

    // Stage 1: saturate, thousands digit and hour.
    st_d[0]        = st_q[0];
    st_d[0].minute = (min_raw > cdd_pkg::MINUTE_MAX) ? cdd_pkg::MINUTE_MAX : min_raw;
    st_d[0].day    = s_axis_tdata[19:11];
    st_d[0].year   = (yr_raw > cdd_pkg::YEAR_MAX) ? cdd_pkg::YEAR_MAX : yr_raw;
    p_thou = 28'(st_d[0].year) * 28'(cdd_pkg::THOU_RECIP);
    p_hour = 22'(st_d[0].minute) * 22'(cdd_pkg::HOUR_RECIP);
    st_d[0].year_thousands = p_thou[26:23];
    st_d[0].hour           = p_hour[20:16];

    // Stage 2: remainders after thousands and hours, hour digits.
    st_d[1] = st_q[0];
    st_d[1].rem_hund = 10'(st_q[0].year - 14'(st_q[0].year_thousands) * 14'd1000);
    st_d[1].mins     = 6'(st_q[0].minute - 11'(st_q[0].hour) * 11'd60);
    if (st_q[0].hour >= 5'd20) begin
      st_d[1].hour_tens = 2'd2;
    end else if (st_q[0].hour >= 5'd10) begin
      st_d[1].hour_tens = 2'd1;
    end else begin
      st_d[1].hour_tens = 2'd0;
    end
    st_d[1].hour_ones = 4'(st_q[0].hour - 5'(st_d[1].hour_tens) * 5'd10);

    // Stage 3: hundreds digit and minute tens.
    st_d[2] = st_q[1];
    p_hund = 16'(st_q[1].rem_hund) * 16'(cdd_pkg::HUND_RECIP);
    p_mt   = 14'(st_q[1].mins) * 14'(cdd_pkg::TEN_RECIP);
    st_d[2].year_hundreds = p_hund[15:12];
    st_d[2].minute_tens   = p_mt[13:11];

    // Stage 4: remainder below hundreds and minute ones.
    st_d[3] = st_q[2];
    st_d[3].rem_ten     = 7'(st_q[2].rem_hund - 10'(st_q[2].year_hundreds) * 10'd100);
    st_d[3].minute_ones = 4'(st_q[2].mins - 6'(st_q[2].minute_tens) * 6'd10);

    // Stage 5: year tens, leap rule and day clamp.
    st_d[4] = st_q[3];
    p_yt = 15'(st_q[3].rem_ten) * 15'(cdd_pkg::TEN_RECIP);
    st_d[4].year_tens = p_yt[14:11];
    cent_low = {st_q[3].year_thousands[0], 1'b0} + st_q[3].year_hundreds[1:0];
    if (st_q[3].rem_ten == 7'd0) begin
      leap = (cent_low == 2'd0);
    end else begin
      leap = (st_q[3].year[1:0] == 2'd0);
    end
    st_d[4].leap = leap;
    len = cdd_pkg::YEAR_LEN + 9'(leap);
    if (st_q[3].day == 9'd0) begin
      dclamp = 9'd1;
    end else if (st_q[3].day > len) begin
      dclamp = len;
    end else begin
      dclamp = st_q[3].day;
    end
    st_d[4].day = dclamp;

    // Stage 6: year ones and the month walk against cumulative month ends.
    st_d[5] = st_q[4];
    st_d[5].year_ones = 4'(st_q[4].rem_ten - 7'(st_q[4].year_tens) * 7'd10);
    mon   = 4'd1;
    start = 9'd0;
    for (int i = 0; i < cdd_pkg::NUM_BOUNDS; i++) begin
      bound = cdd_pkg::month_end(4'(i)) + ((i >= 1) ? 9'(st_q[4].leap) : 9'd0);
      if (st_q[4].day > bound) begin
        mon   = 4'(i + 2);
        start = bound;
      end
    end
    st_d[5].month = mon;
    st_d[5].mday  = 5'(st_q[4].day - start);

    // Stage 7: month and day digits.
    st_d[6] = st_q[5];
    st_d[6].month_tens = (st_q[5].month >= 4'd10);
    st_d[6].month_ones = st_q[5].month - (st_d[6].month_tens ? 4'd10 : 4'd0);
    if (st_q[5].mday >= 5'd30) begin
      st_d[6].day_tens = 2'd3;
    end else if (st_q[5].mday >= 5'd20) begin
      st_d[6].day_tens = 2'd2;
    end else if (st_q[5].mday >= 5'd10) begin
      st_d[6].day_tens = 2'd1;
    end else begin
      st_d[6].day_tens = 2'd0;
    end
    st_d[6].day_ones = 4'(st_q[5].mday - 5'(st_d[6].day_tens) * 5'd10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < N; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    out_w.hour_tens      = st_q[N-1].hour_tens;
    out_w.hour_ones      = st_q[N-1].hour_ones;
    out_w.minute_tens    = st_q[N-1].minute_tens;
    out_w.minute_ones    = st_q[N-1].minute_ones;
    out_w.month_tens     = st_q[N-1].month_tens;
    out_w.month_ones     = st_q[N-1].month_ones;
    out_w.day_tens       = st_q[N-1].day_tens;
    out_w.day_ones       = st_q[N-1].day_ones;
    out_w.year_thousands = st_q[N-1].year_thousands;
    out_w.year_hundreds  = st_q[N-1].year_hundreds;
    out_w.year_tens      = st_q[N-1].year_tens;
    out_w.year_ones      = st_q[N-1].year_ones;
  end

  assign m_axis_tdata  = out_w;
  assign m_axis_tvalid = vld_q[N-1];

`ifndef SYNTH
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output stage is free");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_w.hour_tens == 2'd2) |-> (out_w.hour_ones <= 4'd3))
    else $error("hour above 23");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_w.month_tens && out_w.month_ones <= 4'd2) ||
                       (!out_w.month_tens && out_w.month_ones != 4'd0)))
    else $error("month outside 1 to 12");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_w.day_tens != 2'd0 || out_w.day_ones != 4'd0))
    else $error("day of month is zero");
`endif

endmodule
